// ===== hw/rtl/bpm_pkg.sv =====
`timescale 1ns / 1ps

package bpm_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 5;
	localparam int WIN_W     = 16;
	localparam int FSIZE_W   = 32;
	localparam int OFF_W     = 32;
	localparam int CLEN_W    = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 80;

	localparam int MAX_NEEDLE_DEF    = 16;
	localparam int POSITION_BITS_DEF = 32;

	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HI  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd3;

	localparam logic [LEN_W-1:0] NEEDLE_LEN_RESET = 5'd1;
	localparam logic [WIN_W-1:0] WINDOW_RESET     = 16'd40;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== hw/rtl/byte_pattern_match_with_context_top.sv =====
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                          | tuser | tlast
// s_*     | in  | data_byte[7:0] file_size[39:8]              | -     | end_of_file
// m_*     | out | match_offset[31:0] context_start[63:32]     | -     | -
//         |     | context_length[79:64]                       |       |
// cfg_*   | in  | write: cfg_index selects register, cfg_data |       |
//
// One byte accepted per cycle while s_tready is high.
// Pipeline: input register with history/position, compare and window start,
// then window clipping in the output register.
// arst_n clears the history, position, pipeline valids and registers.
// Each stage holds only while the one after it is full, so m_tready low
// stalls s_tready only once the pipeline has filled.

module byte_pattern_match_with_context_top import bpm_pkg::*; #(
	parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte, file_size
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // match_offset, context_start, context_length
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int REC_D = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
	localparam int POS_W = POSITION_BITS;
	localparam int EXT_W = ((POS_W > WIN_W) ? POS_W : WIN_W) + 1;
	localparam int CMP_W = (EXT_W > FSIZE_W) ? EXT_W : FSIZE_W;

	// configuration
	logic [63:0]        needle_lo_q;
	logic [63:0]        needle_hi_q;
	logic [LEN_W-1:0]   len_q;
	logic [WIN_W-1:0]   win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo_q <= '0;
			needle_hi_q <= '0;
			len_q       <= NEEDLE_LEN_RESET;
			win_q       <= WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEEDLE_LO:  needle_lo_q <= cfg_data;
				REG_NEEDLE_HI:  needle_hi_q <= cfg_data;
				REG_NEEDLE_LEN: len_q       <= cfg_data[LEN_W-1:0];
				REG_WINDOW:     win_q       <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	byte_t [MAX_NEEDLE-1:0] needle;
	for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_needle
		if (k < 8) begin : g_lo
			assign needle[k] = needle_lo_q[8*k +: 8];
		end else begin : g_hi
			assign needle[k] = needle_hi_q[8*(k-8) +: 8];
		end
	end

	logic [LEN_W-1:0] len_eff;
	assign len_eff = (len_q > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : len_q;

	// flow control
	logic v1_s1, v2_s2, m_tvalid_q;
	logic out_free, s2_free, s1_free, accept;

	assign out_free = !m_tvalid_q || m_tready;
	assign s2_free  = !v2_s2 || out_free;
	assign s1_free  = !v1_s1 || s2_free;
	assign s_tready = s1_free;
	assign accept   = s_tvalid && s1_free;

	// history and position
	byte_t              cur;
	logic [FSIZE_W-1:0] fsize;
	byte_t [REC_D-1:0]  recent_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W:0]     pos_inc;
	logic               elig;
	logic [POS_W-1:0]   off;

	assign cur     = s_tdata[BYTE_W-1:0];
	assign fsize   = s_tdata[BYTE_W +: FSIZE_W];
	assign pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);
	assign elig    = (len_eff != '0) && (pos_inc >= (POS_W+1)'(len_eff));
	assign off     = POS_W'(pos_inc - (POS_W+1)'(len_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				recent_q <= '0;
				pos_q    <= '0;
			end else begin
				recent_q[0] <= cur;
				for (int j = 1; j < REC_D; j++) begin
					recent_q[j] <= recent_q[j-1];
				end
				pos_q <= pos_inc[POS_W-1:0];
			end
		end
	end

	// stage 1: captured byte with its history snapshot
	byte_t              cur_s1;
	byte_t [REC_D-1:0]  recent_s1;
	logic [FSIZE_W-1:0] fsize_s1;
	logic               elig_s1;
	logic [POS_W-1:0]   off_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (s1_free) begin
			v1_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1    <= cur;
			recent_s1 <= recent_q;
			fsize_s1  <= fsize;
			elig_s1   <= elig;
			off_s1    <= off;
		end
	end

	logic hit;

	bpm_compare #(
		.MAX_NEEDLE (MAX_NEEDLE),
		.REC_D      (REC_D)
	) u_compare (
		.cur    (cur_s1),
		.recent (recent_s1),
		.needle (needle),
		.len    (len_eff),
		.hit    (hit)
	);

	logic [EXT_W-1:0] off_x, win_x;
	logic [POS_W-1:0] from;

	assign off_x = EXT_W'(off_s1);
	assign win_x = EXT_W'(win_q);
	assign from  = (off_x > win_x) ? POS_W'(off_x - (win_x >> 1)) : '0;

	// stage 2: matches only
	logic [POS_W-1:0]   off_s2;
	logic [POS_W-1:0]   from_s2;
	logic [FSIZE_W-1:0] fsize_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (s2_free) begin
			v2_s2 <= v1_s1 && elig_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && v1_s1) begin
			off_s2   <= off_s1;
			from_s2  <= from;
			fsize_s2 <= fsize_s1;
		end
	end

	// output: clip window at file end
	logic [CMP_W-1:0] end_x, fsize_x, from_x, to_x;
	logic [CLEN_W-1:0] clen;

	assign from_x  = CMP_W'(from_s2);
	assign end_x   = from_x + CMP_W'(win_q);
	assign fsize_x = CMP_W'(fsize_s2);
	assign to_x    = (end_x > fsize_x) ? fsize_x : end_x;
	assign clen    = (to_x > from_x) ? CLEN_W'(to_x - from_x) : '0;

	logic [M_TDATA_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v2_s2) begin
			m_tdata_q <= {clen, OFF_W'(from_s2), OFF_W'(off_s2)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_eof_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> pos_q == '0 && recent_q[0] == '0)
		else $error("position or history not cleared after end of file");

	a_pos_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tlast |=> pos_q == $past(pos_inc[POS_W-1:0]))
		else $error("position did not advance");

	a_history_shift: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tlast |=> recent_q[0] == $past(cur))
		else $error("history did not take the accepted byte");

	a_from_le_off: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 |-> from_s2 <= off_s2)
		else $error("window start beyond match offset");

	a_clen_le_win: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> m_tdata_q[M_TDATA_W-1 -: CLEN_W] <= win_q)
		else $error("context length exceeds window size");

endmodule

// ===== hw/rtl/bpm_compare.sv =====
`timescale 1ns / 1ps

module bpm_compare import bpm_pkg::*; #(
	parameter int MAX_NEEDLE = MAX_NEEDLE_DEF,
	parameter int REC_D      = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1
) (
	input  byte_t                  cur,
	input  byte_t [REC_D-1:0]      recent,
	input  byte_t [MAX_NEEDLE-1:0] needle,
	input  logic  [LEN_W-1:0]      len,
	output logic                   hit
);

	localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

	byte_t [MAX_NEEDLE-1:0] win;

	// win[0] is the current byte, win[j] the byte j positions back
	assign win[0] = cur;
	for (genvar j = 1; j < MAX_NEEDLE; j++) begin : g_win
		assign win[j] = recent[j-1];
	end

	always_comb begin
		logic [LEN_W-1:0] diff;
		diff = '0;
		hit  = (len != '0);
		for (int k = 0; k < MAX_NEEDLE; k++) begin
			if (LEN_W'(k) < len) begin
				diff = len - LEN_W'(1) - LEN_W'(k);
				if (win[diff[IDX_W-1:0]] != needle[k]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule
